/* hw/rtl/pidsf_pkg.sv */
package pidsf_pkg;

	localparam int MEAS_W  = 32;
	localparam int DRIVE_W = 32;
	localparam int GAIN_W  = 48;
	localparam int CFG_W   = 48;
	localparam int ERR_W   = 33;
	localparam int DERR_W  = 34;
	localparam int REF_W   = 40;
	localparam int LIM_W   = 32;
	localparam int FLOOR_W = REF_W - 1;

	localparam logic signed [REF_W-1:0] REF_MAX = {1'b0, {(REF_W-1){1'b1}}};
	localparam logic signed [REF_W-1:0] REF_MIN = {1'b1, {(REF_W-1){1'b0}}};
	localparam logic [REF_W:0] SLEW_UP_STEP   = (REF_W+1)'(150);
	localparam logic [REF_W:0] SLEW_DOWN_STEP = (REF_W+1)'(300);

	localparam logic [LIM_W-1:0] MAX_OUTPUT_RST = '1;
	localparam logic [LIM_W-1:0] MIN_OUTPUT_RST = LIM_W'(1800);
	localparam logic [LIM_W-1:0] SLEW_THR_RST   = LIM_W'(2000);

	// divide by three: x < 3 * 2^32, q = (x * ceil(2^35 / 3)) >> 35
	localparam int DIV_X_W   = 34;
	localparam int DIV_M_W   = 17;
	localparam int DIV_P_W   = DIV_X_W + DIV_M_W;
	localparam int DIV_SUM_W = DIV_X_W + 2 * DIV_M_W;
	localparam int DIV_SHIFT = 35;
	localparam logic [2*DIV_M_W-1:0] DIV3_MUL = 34'h2_AAAA_AAAB;
	localparam logic [FLOOR_W-1:0] DIV_LIMIT = FLOOR_W'(34'h3_0000_0000);

	typedef logic [2:0]       cfg_idx_t;
	typedef logic [CFG_W-1:0] cfg_data_t;

	typedef enum logic [2:0] {
		REG_SETPOINT       = 3'd0,
		REG_PROP_GAIN      = 3'd1,
		REG_INTEG_GAIN     = 3'd2,
		REG_DERIV_GAIN     = 3'd3,
		REG_MAX_OUTPUT     = 3'd4,
		REG_MIN_OUTPUT     = 3'd5,
		REG_SLEW_THRESHOLD = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} pidsf_mul_en_t;

endpackage

/* hw/rtl/pidsf_if.sv */
interface pidsf_sample_if;
	import pidsf_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [MEAS_W-1:0] measurement;
	logic                     timer_expired;

	modport source (output valid, output measurement, output timer_expired, input ready);
	modport sink (input valid, input measurement, input timer_expired, output ready);
endinterface

interface pidsf_drive_if;
	import pidsf_pkg::*;

	logic               valid;
	logic               ready;
	logic [DRIVE_W-1:0] drive;

	modport source (output valid, output drive, input ready);
	modport sink (input valid, input drive, output ready);
endinterface

/* hw/rtl/pidsf_mul.sv */
module pidsf_mul #(
	parameter int OP_W = 33
) (
	input  logic                                     clk,
	input  pidsf_pkg::pidsf_mul_en_t                 en,
	input  logic signed [pidsf_pkg::GAIN_W-1:0]      gain,
	input  logic signed [OP_W-1:0]                   op,
	output logic signed [pidsf_pkg::GAIN_W+OP_W-1:0] prod_s4
);
	import pidsf_pkg::*;

	localparam int HALF_G = GAIN_W / 2;
	localparam int LO_W   = 32;
	localparam int HI_W   = OP_W - LO_W;
	localparam int LP_W   = GAIN_W + LO_W + 1;
	localparam int HP_W   = GAIN_W + HI_W;
	localparam int PROD_W = GAIN_W + OP_W;

	logic        [HALF_G-1:0]        gl;
	logic signed [HALF_G-1:0]        gh;
	logic        [LO_W-1:0]          ol;
	logic signed [HI_W-1:0]          oh;

	logic        [HALF_G+LO_W-1:0]   p_ll_s2;
	logic signed [HALF_G+LO_W:0]     p_hl_s2;
	logic signed [HALF_G+HI_W:0]     p_lh_s2;
	logic signed [HALF_G+HI_W-1:0]   p_hh_s2;
	logic signed [LP_W-1:0]          low_s3;
	logic signed [HP_W-1:0]          high_s3;

	assign gl = gain[HALF_G-1:0];
	assign gh = gain[GAIN_W-1:HALF_G];
	assign ol = op[LO_W-1:0];
	assign oh = op[OP_W-1:LO_W];

	always_ff @(posedge clk) begin
		if (en.s2) begin
			p_ll_s2 <= gl * ol;
			p_hl_s2 <= gh * $signed({1'b0, ol});
			p_lh_s2 <= $signed({1'b0, gl}) * oh;
			p_hh_s2 <= gh * oh;
		end
		if (en.s3) begin
			low_s3  <= $signed({{(LP_W-HALF_G-LO_W){1'b0}}, p_ll_s2})
				+ (LP_W'(p_hl_s2) <<< HALF_G);
			high_s3 <= HP_W'(p_lh_s2) + (HP_W'(p_hh_s2) <<< HALF_G);
		end
		if (en.s4) begin
			prod_s4 <= PROD_W'(low_s3) + (PROD_W'(high_s3) <<< LO_W);
		end
	end

endmodule

/* hw/rtl/pid_with_slew_and_floor.sv */
// Channel  Dir  Payload                           Handshake
// sample   in   measurement[31:0] s, timer_expired valid/ready
// result   out  drive[31:0] u                      valid/ready
// cfg      in   cfg_index[2:0], cfg_data[47:0]    cfg_we, write only
//
// One item per cycle sustained while result.ready stays high.
// Slew reference loop closes in stage 7: one compare and step per unstalled cycle.
// Reset loads the register defaults and clears error history, sum, reference, valids.
// A stage holds only while the stage after it is full and held; bubbles collapse,
// so items keep entering while a result waits at the output register.
module pid_with_slew_and_floor #(
	parameter int GAIN_FRAC_BITS = 32,
	parameter int SUM_WIDTH      = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  pidsf_pkg::cfg_idx_t   cfg_index,
	input  pidsf_pkg::cfg_data_t  cfg_data,
	pidsf_sample_if.sink          sample,
	pidsf_drive_if.source         result
);
	import pidsf_pkg::*;

	localparam int ACC_W = GAIN_W + SUM_WIDTH + 2;
	localparam int INT_W = ACC_W - GAIN_FRAC_BITS;
	localparam logic signed [GAIN_W-1:0] PROP_RST = GAIN_W'(20) << GAIN_FRAC_BITS;
	localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

	logic signed [MEAS_W-1:0] setpoint_q;
	logic signed [GAIN_W-1:0] prop_gain_q, integ_gain_q, deriv_gain_q;
	logic        [LIM_W-1:0]  max_output_q, min_output_q, slew_thr_q;

	logic signed [ERR_W-1:0]     last_err_q, prev_err_q;
	logic signed [SUM_WIDTH-1:0] err_sum_q;
	logic signed [REF_W-1:0]     slew_ref_q;

	logic [10:1] vld_q;
	logic [10:1] vld_prev;
	logic [11:1] rdy;

	logic signed [ERR_W-1:0]     err;
	logic signed [SUM_WIDTH:0]   sum_ext;
	logic signed [SUM_WIDTH-1:0] sum_next;
	logic signed [DERR_W-1:0]    derr;

	logic signed [ERR_W-1:0]     err_s1;
	logic signed [SUM_WIDTH-1:0] sum_s1;
	logic signed [DERR_W-1:0]    derr_s1;
	logic timer_s1, timer_s2, timer_s3, timer_s4, timer_s5;
	logic timer_s6, timer_s7, timer_s8, timer_s9;

	pidsf_mul_en_t mul_en;
	logic signed [GAIN_W+ERR_W-1:0]     prop_s4;
	logic signed [GAIN_W+SUM_WIDTH-1:0] integ_s4;
	logic signed [GAIN_W+DERR_W-1:0]    deriv_s4;

	logic signed [ACC_W-1:0] acc_s5;

	logic signed [INT_W-1:0] int_part;
	logic                    fits;
	logic signed [REF_W-1:0] fl_sat;
	logic signed [REF_W-1:0] fl_s6;
	logic                    frac_s6;

	logic signed [REF_W:0]   diff;
	logic signed [REF_W+1:0] diff_w, below, thr_w;
	logic                    up, trig;
	logic signed [REF_W:0]   ref_up, ref_dn;
	logic signed [REF_W-1:0] ref_next;
	logic signed [REF_W-1:0] fl_s7;

	logic [FLOOR_W-1:0] x_s8;

	logic [DIV_P_W-1:0] p_hi_s9, p_lo_s9;
	logic               big_s9;
	logic [LIM_W-1:0]   cap_s9;

	logic [DIV_SUM_W-1:0] div_sum;
	logic [DRIVE_W-1:0]   drive_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q   <= '0;
			prop_gain_q  <= PROP_RST;
			integ_gain_q <= '0;
			deriv_gain_q <= '0;
			max_output_q <= MAX_OUTPUT_RST;
			min_output_q <= MIN_OUTPUT_RST;
			slew_thr_q   <= SLEW_THR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SETPOINT:       setpoint_q   <= cfg_data[MEAS_W-1:0];
				REG_PROP_GAIN:      prop_gain_q  <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN:     integ_gain_q <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:     deriv_gain_q <= cfg_data[GAIN_W-1:0];
				REG_MAX_OUTPUT:     max_output_q <= cfg_data[LIM_W-1:0];
				REG_MIN_OUTPUT:     min_output_q <= cfg_data[LIM_W-1:0];
				REG_SLEW_THRESHOLD: slew_thr_q   <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		rdy[11] = result.ready;
		for (int i = 10; i >= 1; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	assign vld_prev     = {vld_q[9:1], sample.valid};
	assign sample.ready = rdy[1];
	assign result.valid = vld_q[10];
	assign result.drive = drive_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= 10; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vld_prev[i];
				end
			end
		end
	end

	// error history and saturating sum advance as each item is taken
	always_comb begin
		err     = ERR_W'(setpoint_q) - ERR_W'(sample.measurement);
		sum_ext = (SUM_WIDTH+1)'(err_sum_q) + (SUM_WIDTH+1)'(err);
		if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
			sum_next = sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_next = sum_ext[SUM_WIDTH-1:0];
		end
		derr = DERR_W'(last_err_q) - DERR_W'(prev_err_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
			prev_err_q <= '0;
			err_sum_q  <= '0;
		end else if (sample.valid && rdy[1]) begin
			last_err_q <= err;
			prev_err_q <= last_err_q;
			err_sum_q  <= sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			err_s1   <= err;
			sum_s1   <= sum_next;
			derr_s1  <= derr;
			timer_s1 <= sample.timer_expired;
		end
		if (rdy[2]) timer_s2 <= timer_s1;
		if (rdy[3]) timer_s3 <= timer_s2;
		if (rdy[4]) timer_s4 <= timer_s3;
		if (rdy[5]) timer_s5 <= timer_s4;
		if (rdy[6]) timer_s6 <= timer_s5;
		if (rdy[7]) timer_s7 <= timer_s6;
		if (rdy[8]) timer_s8 <= timer_s7;
		if (rdy[9]) timer_s9 <= timer_s8;
	end

	assign mul_en.s2 = rdy[2];
	assign mul_en.s3 = rdy[3];
	assign mul_en.s4 = rdy[4];

	pidsf_mul #(.OP_W(ERR_W)) u_mul_prop (
		.clk     (clk),
		.en      (mul_en),
		.gain    (prop_gain_q),
		.op      (err_s1),
		.prod_s4 (prop_s4)
	);

	pidsf_mul #(.OP_W(SUM_WIDTH)) u_mul_integ (
		.clk     (clk),
		.en      (mul_en),
		.gain    (integ_gain_q),
		.op      (sum_s1),
		.prod_s4 (integ_s4)
	);

	pidsf_mul #(.OP_W(DERR_W)) u_mul_deriv (
		.clk     (clk),
		.en      (mul_en),
		.gain    (deriv_gain_q),
		.op      (derr_s1),
		.prod_s4 (deriv_s4)
	);

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			acc_s5 <= ACC_W'(prop_s4) + ACC_W'(integ_s4) + ACC_W'(deriv_s4);
		end
	end

	always_comb begin
		int_part = acc_s5[ACC_W-1:GAIN_FRAC_BITS];
		fits     = (&int_part[INT_W-1:REF_W-1]) || !(|int_part[INT_W-1:REF_W-1]);
		if (fits) begin
			fl_sat = int_part[REF_W-1:0];
		end else begin
			fl_sat = int_part[INT_W-1] ? REF_MIN : REF_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			fl_s6   <= fl_sat;
			frac_s6 <= (|acc_s5[GAIN_FRAC_BITS-1:0]) && (fl_sat != REF_MIN)
				&& (fl_sat != REF_MAX);
		end
	end

	always_comb begin
		diff   = (REF_W+1)'(fl_s6) - (REF_W+1)'(slew_ref_q);
		diff_w = (REF_W+2)'(diff);
		below  = -diff_w - $signed((REF_W+2)'(frac_s6));
		thr_w  = $signed((REF_W+2)'(slew_thr_q));
		up     = (diff > 0) || ((diff == 0) && frac_s6);
		trig   = up ? (diff_w >= thr_w) : (below >= thr_w);
		ref_up = (REF_W+1)'(slew_ref_q) + $signed(SLEW_UP_STEP);
		ref_dn = (REF_W+1)'(slew_ref_q) - $signed(SLEW_DOWN_STEP);
		if (up) begin
			ref_next = (ref_up[REF_W] != ref_up[REF_W-1]) ? REF_MAX : ref_up[REF_W-1:0];
		end else begin
			ref_next = (ref_dn[REF_W] != ref_dn[REF_W-1]) ? REF_MIN : ref_dn[REF_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slew_ref_q <= '0;
		end else if (rdy[7] && vld_q[6] && trig) begin
			slew_ref_q <= ref_next;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			fl_s7 <= trig ? ref_next : fl_s6;
		end
		if (rdy[8]) begin
			if (fl_s7 < $signed({{(REF_W-LIM_W){1'b0}}, min_output_q})) begin
				x_s8 <= FLOOR_W'(min_output_q);
			end else begin
				x_s8 <= fl_s7[FLOOR_W-1:0];
			end
		end
		if (rdy[9]) begin
			p_hi_s9 <= x_s8[DIV_X_W-1:0] * DIV3_MUL[2*DIV_M_W-1:DIV_M_W];
			p_lo_s9 <= x_s8[DIV_X_W-1:0] * DIV3_MUL[DIV_M_W-1:0];
			big_s9  <= x_s8 >= DIV_LIMIT;
			cap_s9  <= (x_s8 >= FLOOR_W'(max_output_q)) ? max_output_q : x_s8[LIM_W-1:0];
		end
	end

	assign div_sum = (DIV_SUM_W'(p_hi_s9) << DIV_M_W) + DIV_SUM_W'(p_lo_s9);

	always_ff @(posedge clk) begin
		if (rdy[10]) begin
			if (timer_s9) begin
				drive_s10 <= cap_s9;
			end else if (big_s9) begin
				drive_s10 <= '1;
			end else begin
				drive_s10 <= div_sum[DIV_SHIFT+DRIVE_W-1:DIV_SHIFT];
			end
		end
	end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import pidsf_pkg::*;

	localparam int      FRAC_BITS   = 32;
	localparam int      SUM_W       = 48;
	localparam longint  SUM_TOP     = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
	localparam longint  SUM_BOT     = -SUM_TOP - 64'sd1;
	localparam longint  REF_TOP     = REF_MAX;
	localparam longint  REF_BOT     = REF_MIN;
	localparam longint  STEP_UP     = SLEW_UP_STEP;
	localparam longint  STEP_DOWN   = SLEW_DOWN_STEP;
	localparam int      SETTLE      = 16;
	localparam int      CYCLE_LIMIT = 1_000_000;
	localparam int      ROUNDS      = 8;
	localparam int      ROUND_ITEMS = 160;
	localparam int      SUM_ITEMS   = 150;

	localparam logic [47:0] GAIN_TOP = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] GAIN_BOT = 48'h8000_0000_0000;
	localparam logic [47:0] LIM_TOP  = 48'h0000_FFFF_FFFF;
	localparam logic [47:0] SP_TOP   = 48'h0000_7FFF_FFFF;
	localparam logic [47:0] SP_BOT   = 48'hFFFF_8000_0000;
	localparam logic signed [31:0] MEAS_TOP = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] MEAS_BOT = 32'sh8000_0000;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	cfg_idx_t  cfg_index;
	cfg_data_t cfg_data;

	pidsf_sample_if sample_ch();
	pidsf_drive_if  drive_ch();

	pid_with_slew_and_floor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (drive_ch)
	);

	longint setpoint_v, kp_v, ki_v, kd_v, out_max_v, out_min_v, slew_thr_v;
	longint err_last, err_prev, err_sum, slew_ref;

	logic [31:0] drive_expected[$];
	logic [31:0] drive_want;
	int          fail_count;
	bit          no_idle;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	function automatic longint clamp_ref(longint v);
		if (v > REF_TOP)
			return REF_TOP;
		if (v < REF_BOT)
			return REF_BOT;
		return v;
	endfunction

	function automatic logic [31:0] predict_drive(logic signed [31:0] meas, logic timer);
		longint             err, derr, fl, s, q;
		logic signed [127:0] acc, wide_fl, a, b;
		logic               frac, up;
		err = setpoint_v - longint'(meas);
		s = err_sum + err;
		if (s > SUM_TOP)
			s = SUM_TOP;
		else if (s < SUM_BOT)
			s = SUM_BOT;
		err_sum = s;
		derr = err_last - err_prev;
		err_prev = err_last;
		err_last = err;

		a = kp_v; b = err;     acc = a * b;
		a = ki_v; b = err_sum; acc = acc + a * b;
		a = kd_v; b = derr;    acc = acc + a * b;
		frac = |acc[FRAC_BITS-1:0];
		wide_fl = acc >>> FRAC_BITS;
		if (wide_fl > REF_TOP)
			fl = REF_TOP;
		else if (wide_fl < REF_BOT)
			fl = REF_BOT;
		else
			fl = 64'(wide_fl);
		if (fl == REF_TOP || fl == REF_BOT)
			frac = 1'b0;

		up = (fl > slew_ref) || (fl == slew_ref && frac);
		if (up) begin
			if (fl - slew_ref >= slew_thr_v) begin
				slew_ref = clamp_ref(slew_ref + STEP_UP);
				fl = slew_ref;
				frac = 1'b0;
			end
		end else if (slew_ref - fl - (frac ? 64'sd1 : 64'sd0) >= slew_thr_v) begin
			slew_ref = clamp_ref(slew_ref - STEP_DOWN);
			fl = slew_ref;
			frac = 1'b0;
		end

		if (fl < out_min_v)
			fl = out_min_v;
		if (timer)
			return (fl >= out_max_v) ? 32'(out_max_v) : 32'(fl);
		q = fl / 3;
		return (q > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : 32'(q);
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [47:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_SETPOINT:       setpoint_v = longint'($signed(value[31:0]));
			REG_PROP_GAIN:      kp_v = longint'($signed(value));
			REG_INTEG_GAIN:     ki_v = longint'($signed(value));
			REG_DERIV_GAIN:     kd_v = longint'($signed(value));
			REG_MAX_OUTPUT:     out_max_v = longint'(value[31:0]);
			REG_MIN_OUTPUT:     out_min_v = longint'(value[31:0]);
			REG_SLEW_THRESHOLD: slew_thr_v = longint'(value[31:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_settings(logic [47:0] sp, logic [47:0] kp, logic [47:0] ki,
			logic [47:0] kd, logic [47:0] mx, logic [47:0] mn, logic [47:0] thr);
		write_reg(REG_SETPOINT, sp);
		write_reg(REG_PROP_GAIN, kp);
		write_reg(REG_INTEG_GAIN, ki);
		write_reg(REG_DERIV_GAIN, kd);
		write_reg(REG_MAX_OUTPUT, mx);
		write_reg(REG_MIN_OUTPUT, mn);
		write_reg(REG_SLEW_THRESHOLD, thr);
	endtask

	task automatic send_sample(logic signed [31:0] meas, logic timer);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		@(negedge clk);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.measurement <= meas;
		sample_ch.timer_expired <= timer;
		do @(posedge clk); while (!sample_ch.ready);
		drive_expected.push_back(predict_drive(meas, timer));
	endtask

	task automatic settle();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (drive_expected.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		drive_ch.ready = 1'b0;
		forever begin
			int stall;
			stall = no_idle ? 0 : $urandom_range(0, 10);
			@(negedge clk);
			if (stall > 0) begin
				drive_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			drive_ch.ready <= 1'b1;
			do @(posedge clk); while (!drive_ch.valid);
		end
	end

	always @(posedge clk) begin
		if (drive_ch.valid && drive_ch.ready) begin
			if (drive_expected.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("drive %0d with no item pending", drive_ch.drive);
			end else begin
				drive_want = drive_expected.pop_front();
				if (drive_ch.drive !== drive_want) begin
					fail_count++;
					if (fail_count <= 10)
						$display("drive mismatch: expected %0d, got %0d",
							drive_want, drive_ch.drive);
				end
			end
		end
	end

	function automatic logic [47:0] rand_gain(int whole_max);
		longint k;
		k = (longint'($urandom_range(0, whole_max)) <<< 32) | longint'($urandom);
		if ($urandom_range(0, 1))
			k = -k;
		return 48'(k);
	endfunction

	function automatic logic signed [31:0] pick_measurement();
		longint m;
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: return MEAS_TOP;
					1: return MEAS_BOT;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			default: begin
				m = setpoint_v + longint'($urandom_range(0, 800)) - 400;
				if (m > MEAS_TOP)
					m = MEAS_TOP;
				if (m < MEAS_BOT)
					m = MEAS_BOT;
				return 32'(m);
			end
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_sample(32'sd0, 1'b1);
		send_sample(-32'sd200, 1'b1);
		send_sample(-32'sd200, 1'b0);
		send_sample(32'sd200, 1'b0);
		send_sample(-32'sd5000, 1'b1);
		settle();
	endtask

	task automatic test_field_extremes();
		load_settings(SP_TOP, GAIN_TOP, GAIN_BOT, GAIN_TOP, LIM_TOP, 48'd0, LIM_TOP);
		send_sample(MEAS_BOT, 1'b1);
		send_sample(MEAS_TOP, 1'b0);
		send_sample(-32'sd1, 1'b1);
		send_sample(32'sd0, 1'b0);
		settle();
		load_settings(SP_BOT, GAIN_BOT, GAIN_TOP, GAIN_BOT, LIM_TOP, 48'd0, LIM_TOP);
		send_sample(MEAS_TOP, 1'b1);
		send_sample(MEAS_BOT, 1'b1);
		send_sample(32'sd0, 1'b0);
		settle();
	endtask

	task automatic test_slew_edges();
		load_settings(48'd0, 48'h0000_8000_0000, 48'd0, 48'd0, LIM_TOP, 48'd0, 48'd0);
		send_sample(-32'sd1, 1'b1);
		send_sample(-32'sd3, 1'b1);
		send_sample(32'sd3, 1'b1);
		settle();
		write_reg(REG_SLEW_THRESHOLD, 48'd1);
		send_sample(-32'sd301, 1'b1);
		send_sample(-32'sd299, 1'b1);
		settle();
		write_reg(REG_SLEW_THRESHOLD, 48'd2000);
		send_sample(-32'sd9001, 1'b1);
		send_sample(32'sd9001, 1'b0);
		settle();
	endtask

	task automatic test_output_limits();
		load_settings(48'd0, 48'h0014_0000_0000, 48'd0, 48'd0, 48'd0, LIM_TOP, LIM_TOP);
		send_sample(-32'sd1000, 1'b1);
		send_sample(-32'sd1000, 1'b0);
		settle();
		write_reg(REG_MIN_OUTPUT, 48'd0);
		write_reg(REG_MAX_OUTPUT, 48'd1000);
		send_sample(-32'sd100, 1'b1);
		send_sample(-32'sd10, 1'b1);
		send_sample(-32'sd100, 1'b0);
		settle();
	endtask

	task automatic test_random_operation();
		for (int r = 0; r < ROUNDS; r++) begin
			no_idle = (r == 3 || r == 6);
			case (r)
				0: load_settings(SP_TOP, GAIN_TOP, GAIN_TOP, GAIN_TOP, LIM_TOP, LIM_TOP, LIM_TOP);
				1: load_settings(SP_BOT, GAIN_BOT, GAIN_BOT, GAIN_BOT, 48'd0, 48'd0, 48'd0);
				default: load_settings(
					($urandom_range(0, 3) == 0) ? 48'($signed($urandom))
						: 48'(longint'($urandom_range(0, 20000)) - 10000),
					rand_gain(40),
					48'(longint'($urandom_range(0, 1 << 20)) - (1 << 19)),
					rand_gain(8),
					($urandom_range(0, 1)) ? 48'($urandom) : 48'($urandom_range(1000, 65535)),
					48'($urandom_range(0, 3000)),
					48'($urandom_range(0, 5000)));
			endcase
			for (int i = 0; i < ROUND_ITEMS; i++)
				send_sample(pick_measurement(), 1'($urandom_range(0, 1)));
			settle();
		end
		no_idle = 1'b0;
	endtask

	task automatic test_sum_extremes();
		no_idle = 1'b1;
		load_settings(SP_TOP, 48'd0, 48'h0000_0000_0100, 48'd0, LIM_TOP, 48'd0, LIM_TOP);
		for (int i = 0; i < SUM_ITEMS; i++)
			send_sample(MEAS_BOT, 1'($urandom_range(0, 1)));
		settle();
		write_reg(REG_SETPOINT, SP_BOT);
		for (int i = 0; i < SUM_ITEMS; i++)
			send_sample(MEAS_TOP, 1'($urandom_range(0, 1)));
		settle();
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SETPOINT;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.measurement = '0;
		sample_ch.timer_expired = 1'b0;
		no_idle = 1'b0;
		fail_count = 0;
		setpoint_v = 0;
		kp_v = 64'sd20 <<< FRAC_BITS;
		ki_v = 0;
		kd_v = 0;
		out_max_v = longint'(MAX_OUTPUT_RST);
		out_min_v = longint'(MIN_OUTPUT_RST);
		slew_thr_v = longint'(SLEW_THR_RST);
		err_last = 0;
		err_prev = 0;
		err_sum = 0;
		slew_ref = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_field_extremes();
		test_slew_edges();
		test_output_limits();
		test_random_operation();
		test_sum_extremes();

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
